// File: rtl/core/kat_pkg.sv
// Shared widths, command and status codes, and token control type for the keyed append table.
`timescale 1ns / 1ps

package kat_pkg;

	localparam int CMD_W    = 3;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;
	localparam int CAP_W    = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FIRST  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LAST   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REWIND = 3'd4;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
	localparam logic [STATUS_W-1:0] ST_END   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MISS  = 3'd4;

	typedef logic [1:0] op_t;

	localparam op_t OP_NOP  = 2'd0;
	localparam op_t OP_WR   = 2'd1;
	localparam op_t OP_RD   = 2'd2;
	localparam op_t OP_SRCH = 2'd3;

	// Control part of the token that walks along the row of cells.
	typedef struct packed {
		logic valid;
		op_t  op;
		logic found;
	} tok_ctl_t;

endpackage

// File: rtl/core/kat_if.sv
// Command and result channel interfaces of the keyed append table.
`timescale 1ns / 1ps

interface kat_cmd_if import kat_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [DATA_W-1:0] in_key;
	logic [DATA_W-1:0] in_value;

	modport source (output valid, output command, output in_key, output in_value, input ready);
	modport sink   (input valid, input command, input in_key, input in_value, output ready);
endinterface

interface kat_res_if import kat_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   out_key;
	logic [DATA_W-1:0]   out_value;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count;

	modport source (output valid, output out_key, output out_value, output status,
		output count, input ready);
	modport sink   (input valid, input out_key, input out_value, input status,
		input count, output ready);
endinterface

// File: rtl/core/kat_cell.sv
// One table cell: holds one key/value entry and forwards the token to its neighbor.
`timescale 1ns / 1ps

module kat_cell import kat_pkg::*; #(
	parameter int KW = 32,
	parameter int VW = 32,
	parameter int IW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] cell_idx,
	input  tok_ctl_t      in_ctl,
	input  logic [IW-1:0] in_idx,
	input  logic [KW-1:0] in_key,
	input  logic [VW-1:0] in_val,
	output tok_ctl_t      out_ctl,
	output logic [IW-1:0] out_idx,
	output logic [KW-1:0] out_key,
	output logic [VW-1:0] out_val
);

	logic [KW-1:0] ent_key_q;
	logic [VW-1:0] ent_val_q;
	tok_ctl_t      ctl_q;
	logic [IW-1:0] idx_q;
	logic [KW-1:0] key_q;
	logic [VW-1:0] val_q;
	logic          wr_hit;
	logic          rd_hit;
	logic          sr_hit;

	assign wr_hit = in_ctl.valid && (in_ctl.op == OP_WR) && (in_idx == cell_idx);
	assign rd_hit = in_ctl.valid && (in_ctl.op == OP_RD) && (in_idx == cell_idx);
	// For a search the index field carries the fill count until a match replaces it.
	assign sr_hit = in_ctl.valid && (in_ctl.op == OP_SRCH) && !in_ctl.found &&
		(cell_idx < in_idx) && (ent_key_q == in_key);

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			ent_key_q <= in_key;
			ent_val_q <= in_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= '{valid: in_ctl.valid, op: in_ctl.op, found: in_ctl.found | sr_hit};
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= sr_hit ? cell_idx : in_idx;
		key_q <= (rd_hit || sr_hit) ? ent_key_q : in_key;
		val_q <= (rd_hit || sr_hit) ? ent_val_q : in_val;
	end

	assign out_ctl = ctl_q;
	assign out_idx = idx_q;
	assign out_key = key_q;
	assign out_val = val_q;

endmodule

// File: rtl/core/keyed_append_table.sv
// Top level of the keyed append table: command decode, token launch, result return.
`timescale 1ns / 1ps

// The keyed append table stores up to DEPTH key/value entries in a row of DEPTH
// cells, filled in order and never removed. Each command transaction (append,
// first, last, next, rewind, lookup) launches one token into cell 0; the token
// moves one cell per clock, and the cell it addresses writes or returns its
// entry, while a lookup compares the key in every cell it passes and keeps the
// lowest match. A command is accepted only when the table is idle, and the
// next one can be accepted once the token has crossed the row, the result
// has been captured and it has moved from the capture stage into the
// output register. The result then waits there without holding up the next
// command; if the output register still holds an untaken result when the next
// one is captured, that one waits in the capture stage and the table stays
// busy until the sink takes the older result. The capacity register (reset 16)
// limits appends to min(capacity, DEPTH); the user must write it through cfg_we
// and cfg_wdata while the table is idle, unchecked by the block. Entries need
// no clearing after reset, since only entries below the fill count are ever read.

module keyed_append_table import kat_pkg::*; #(
	parameter int DEPTH       = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	kat_cmd_if.sink          cmd,
	kat_res_if.source        res
);

	// Stored widths never exceed the port width, since keys and values arrive on
	// 32-bit fields.
	localparam int KW = (KEY_WIDTH < DATA_W) ? KEY_WIDTH : DATA_W;
	localparam int VW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
	// Index and count width: must hold DEPTH itself.
	localparam int CW = $clog2(DEPTH + 1);
	// Width used to compare the fill count against the capacity register.
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0]    cap_q;
	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       cursor_q;
	logic                busy_q;
	logic [STATUS_W-1:0] st_q;

	// Token chain: position 0 is the launch point, position DEPTH leaves the row.
	tok_ctl_t      ctl_c [DEPTH+1];
	logic [CW-1:0] idx_c [DEPTH+1];
	logic [KW-1:0] key_c [DEPTH+1];
	logic [VW-1:0] val_c [DEPTH+1];

	logic                accept;
	logic                full;
	op_t                 dec_op;
	logic [CW-1:0]       dec_idx;
	logic [STATUS_W-1:0] dec_st;

	// Result waiting between the end of the row and the output register.
	logic                pend_valid_q;
	logic [DATA_W-1:0]   pend_key_q;
	logic [DATA_W-1:0]   pend_val_q;
	logic [STATUS_W-1:0] pend_st_q;
	logic                pend_move;

	logic                out_valid_q;
	logic [DATA_W-1:0]   out_key_q;
	logic [DATA_W-1:0]   out_val_q;
	logic [STATUS_W-1:0] out_st_q;
	logic [COUNT_W-1:0]  out_cnt_q;

	logic exit_valid;
	logic exit_hit;
	logic exit_srch;

	assign cmd.ready = !busy_q;
	assign accept    = cmd.valid && !busy_q;

	// The table is full once the fill count reaches either the capacity register
	// or the physical depth.
	assign full = (LW'(fill_q) >= LW'(cap_q)) || (LW'(fill_q) >= LW'(DEPTH));

	// Command decode. Errors that depend only on the count and cursor are settled
	// here, and such commands launch a token that does nothing.
	always_comb begin
		dec_op  = OP_NOP;
		dec_idx = '0;
		dec_st  = ST_OK;
		case (cmd.command)
			CMD_APPEND: begin
				if (full) begin
					dec_st = ST_FULL;
				end else begin
					dec_op  = OP_WR;
					dec_idx = fill_q;
				end
			end
			CMD_FIRST, CMD_LAST: begin
				if (fill_q == '0) begin
					dec_st = ST_EMPTY;
				end else begin
					dec_op  = OP_RD;
					dec_idx = (cmd.command == CMD_FIRST) ? '0 : fill_q - 1'b1;
				end
			end
			CMD_NEXT: begin
				if (cursor_q >= fill_q) begin
					dec_st = ST_END;
				end else begin
					dec_op  = OP_RD;
					dec_idx = cursor_q;
				end
			end
			CMD_REWIND: begin
				if (fill_q == '0) begin
					dec_st = ST_EMPTY;
				end
			end
			CMD_LOOKUP: begin
				// The search carries the fill count so cells past it never match.
				dec_op  = OP_SRCH;
				dec_idx = fill_q;
			end
			default: begin
			end
		endcase
	end

	assign ctl_c[0] = '{valid: accept, op: dec_op, found: 1'b0};
	assign idx_c[0] = dec_idx;
	assign key_c[0] = KW'(cmd.in_key);
	assign val_c[0] = VW'(cmd.in_value);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		kat_cell #(
			.KW (KW),
			.VW (VW),
			.IW (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (CW'(i)),
			.in_ctl   (ctl_c[i]),
			.in_idx   (idx_c[i]),
			.in_key   (key_c[i]),
			.in_val   (val_c[i]),
			.out_ctl  (ctl_c[i+1]),
			.out_idx  (idx_c[i+1]),
			.out_key  (key_c[i+1]),
			.out_val  (val_c[i+1])
		);
	end

	assign exit_valid = ctl_c[DEPTH].valid;
	assign exit_srch  = ctl_c[DEPTH].op == OP_SRCH;
	assign exit_hit   = (ctl_c[DEPTH].op == OP_RD) || (exit_srch && ctl_c[DEPTH].found);

	assign pend_move = pend_valid_q && (!out_valid_q || res.ready);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Fill count and cursor. Appends, next and rewind update them at acceptance;
	// a lookup moves the cursor only when its token leaves the row with a match.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			cursor_q <= '0;
		end else if (accept) begin
			if (dec_op == OP_WR) begin
				fill_q <= fill_q + 1'b1;
			end
			if ((cmd.command == CMD_NEXT) && (dec_op == OP_RD)) begin
				cursor_q <= cursor_q + 1'b1;
			end
			if ((cmd.command == CMD_REWIND) && (fill_q != '0)) begin
				cursor_q <= '0;
			end
		end else if (exit_valid && exit_srch && ctl_c[DEPTH].found) begin
			cursor_q <= idx_c[DEPTH] + 1'b1;
		end
	end

	// The table is busy from acceptance until the result reaches the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (pend_move) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_q <= dec_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (exit_valid) begin
			pend_valid_q <= 1'b1;
		end else if (pend_move) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exit_valid) begin
			pend_key_q <= exit_hit ? DATA_W'(key_c[DEPTH]) : '0;
			pend_val_q <= exit_hit ? DATA_W'(val_c[DEPTH]) : '0;
			if (exit_srch) begin
				pend_st_q <= ctl_c[DEPTH].found ? ST_OK : ST_MISS;
			end else begin
				pend_st_q <= st_q;
			end
		end
	end

	// Output register: holds a finished result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_move) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The fill count no longer changes once the token is in the row, so it is
	// sampled here as the count after the command.
	always_ff @(posedge clk) begin
		if (pend_move) begin
			out_key_q <= pend_key_q;
			out_val_q <= pend_val_q;
			out_st_q  <= pend_st_q;
			out_cnt_q <= COUNT_W'(fill_q);
		end
	end

	assign res.valid     = out_valid_q;
	assign res.out_key   = out_key_q;
	assign res.out_value = out_val_q;
	assign res.status    = out_st_q;
	assign res.count     = out_cnt_q;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the keyed append table: random command traffic against a predictor.
`timescale 1ns / 1ps

module tb;
	import kat_pkg::*;

	localparam int DEPTH          = 16;
	localparam int DRAIN_CYCLES   = DEPTH + 6;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int KEY_POOL_N     = 8;
	localparam int PRINT_LIMIT    = 200;

	// The two command codes the block treats as no-ops.
	localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic [DATA_W-1:0]   key;
		logic [DATA_W-1:0]   value;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} resp_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	kat_cmd_if cmd_ch ();
	kat_res_if res_ch ();

	keyed_append_table #(
		.DEPTH      (DEPTH),
		.KEY_WIDTH  (32),
		.VALUE_WIDTH(32)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd_ch),
		.res      (res_ch)
	);

	always #5 clk = ~clk;

	// Predicted contents of the table, updated as each command transaction is accepted.
	logic [DATA_W-1:0] table_keys [DEPTH];
	logic [DATA_W-1:0] table_values [DEPTH];
	int unsigned       fill_level;
	int unsigned       walk_pos;
	int unsigned       capacity_shadow;

	cmd_item_t   cmd_backlog[$];
	resp_t       pending_responses[$];
	logic [31:0] key_pool [KEY_POOL_N];
	int          mismatches;
	int          burst_left;
	int          gap_left;
	int          idle_cycles;

	function automatic resp_t predict_response(cmd_item_t it);
		resp_t       r;
		int unsigned limit;
		r        = '0;
		r.status = ST_OK;
		limit    = (capacity_shadow < DEPTH) ? capacity_shadow : DEPTH;
		case (it.command)
			CMD_APPEND: begin
				if (fill_level >= limit) begin
					r.status = ST_FULL;
				end else begin
					table_keys[fill_level]   = it.key;
					table_values[fill_level] = it.value;
					fill_level++;
				end
			end
			CMD_FIRST, CMD_LAST: begin
				if (fill_level == 0) begin
					r.status = ST_EMPTY;
				end else if (it.command == CMD_FIRST) begin
					r.key   = table_keys[0];
					r.value = table_values[0];
				end else begin
					r.key   = table_keys[fill_level - 1];
					r.value = table_values[fill_level - 1];
				end
			end
			CMD_NEXT: begin
				// The cursor stops at the fill level, and the last entry is still returned.
				if (walk_pos >= fill_level) begin
					r.status = ST_END;
				end else begin
					r.key   = table_keys[walk_pos];
					r.value = table_values[walk_pos];
					walk_pos++;
				end
			end
			CMD_REWIND: begin
				if (fill_level == 0)
					r.status = ST_EMPTY;
				else
					walk_pos = 0;
			end
			CMD_LOOKUP: begin
				// The lowest matching entry wins, and the cursor lands just past it.
				r.status = ST_MISS;
				for (int i = 0; i < fill_level; i++) begin
					if (table_keys[i] == it.key) begin
						r.key    = table_keys[i];
						r.value  = table_values[i];
						r.status = ST_OK;
						walk_pos = i + 1;
						break;
					end
				end
			end
			default: begin
			end
		endcase
		r.count = fill_level[COUNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic queue_cmd(input logic [CMD_W-1:0] command, input logic [31:0] key,
		input logic [31:0] value);
		cmd_item_t it;
		it.command = command;
		it.key     = key;
		it.value   = value;
		cmd_backlog = {cmd_backlog, it};
	endtask

	// Random traffic: mostly appends, walks and lookups, with keys drawn from a small pool
	// so that lookups hit and duplicate keys show up in the table.
	task automatic add_random_items(input int n);
		cmd_item_t it;
		int        pick;
		for (int k = 0; k < n; k++) begin
			pick     = $urandom_range(0, 99);
			it.key   = ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, KEY_POOL_N - 1)];
			it.value = $urandom;
			if (pick < 24)
				it.command = CMD_APPEND;
			else if (pick < 31)
				it.command = CMD_FIRST;
			else if (pick < 38)
				it.command = CMD_LAST;
			else if (pick < 58)
				it.command = CMD_NEXT;
			else if (pick < 65)
				it.command = CMD_REWIND;
			else if (pick < 97)
				it.command = CMD_LOOKUP;
			else if (pick < 99)
				it.command = CMD_SPARE6;
			else
				it.command = CMD_SPARE7;
			cmd_backlog = {cmd_backlog, it};
		end
	endtask

	// Waits until the table is idle with nothing outstanding, then lets it settle.
	task automatic drain();
		while (cmd_backlog.size() != 0 || cmd_ch.valid || pending_responses.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_capacity(input logic [CAP_W-1:0] cap);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we    <= 1'b0;
		capacity_shadow = cap;
		@(negedge clk);
	endtask

	// Command driver: offers items from the backlog in bursts separated by random gaps.
	always @(posedge clk) begin
		logic  nxt_valid;
		resp_t nxt_resp;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			nxt_valid = cmd_ch.valid;
			if (cmd_ch.valid && cmd_ch.ready) begin
				nxt_resp          = predict_response(cmd_backlog.pop_front());
				pending_responses = {pending_responses, nxt_resp};
				nxt_valid = 1'b0;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				end
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_backlog.size() != 0) begin
					nxt_valid          = 1'b1;
					cmd_ch.command    <= cmd_backlog[0].command;
					cmd_ch.in_key     <= cmd_backlog[0].key;
					cmd_ch.in_value   <= cmd_backlog[0].value;
				end
			end
			cmd_ch.valid <= nxt_valid;
		end
	end

	// Result receiver: switches among stall patterns, and once holds off for a long
	// stretch while the backlog is deep so that the block backs up onto its input.
	int   rx_seen;
	int   rx_cycle;
	int   stall_mode;
	int   hold_cycles;
	logic hold_done;

	always @(posedge clk) begin
		logic nxt_ready;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				rx_seen++;
			rx_cycle++;
			if (!hold_done && rx_seen >= 300 && cmd_backlog.size() >= 40) begin
				hold_done   = 1'b1;
				hold_cycles = 400;
			end
			if (rx_cycle % 97 == 0)
				stall_mode = $urandom_range(0, 3);
			if (hold_cycles > 0) begin
				hold_cycles--;
				nxt_ready = 1'b0;
			end else begin
				case (stall_mode)
					0:       nxt_ready = 1'b1;
					1:       nxt_ready = ($urandom_range(0, 3) != 0);
					2:       nxt_ready = ((rx_cycle % 7) >= 3);
					default: nxt_ready = $urandom_range(0, 1);
				endcase
			end
			res_ch.ready <= nxt_ready;
		end
	end

	// Result checker: each result transaction is matched against the oldest prediction.
	always @(posedge clk) begin
		resp_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_responses.size() == 0) begin
				report_mismatch("unexpected result key", res_ch.out_key, '0);
			end else begin
				want = pending_responses.pop_front();
				if (res_ch.out_key !== want.key)
					report_mismatch("out_key", res_ch.out_key, want.key);
				if (res_ch.out_value !== want.value)
					report_mismatch("out_value", res_ch.out_value, want.value);
				if (res_ch.status !== want.status)
					report_mismatch("status", 32'(res_ch.status), 32'(want.status));
				if (res_ch.count !== want.count)
					report_mismatch("count", 32'(res_ch.count), 32'(want.count));
			end
		end
	end

	// Watchdog on cycles without any transaction on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[keyed_append_table] ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [CAP_W-1:0] phase_caps [9];
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.command  = CMD_APPEND;
		cmd_ch.in_key   = '0;
		cmd_ch.in_value = '0;
		res_ch.ready    = 1'b0;
		fill_level      = 0;
		walk_pos        = 0;
		capacity_shadow = CAP_RESET;
		mismatches      = 0;
		idle_cycles     = 0;
		gap_left        = 0;
		burst_left      = $urandom_range(1, 40);
		rx_seen         = 0;
		rx_cycle        = 0;
		stall_mode      = 0;
		hold_cycles     = 0;
		hold_done       = 1'b0;
		phase_caps      = '{5'd3, 5'd6, 5'd10, 5'd31, 5'd16, 5'd0, 5'd12, 5'd20, 5'd1};
		for (int i = 0; i < KEY_POOL_N; i++)
			key_pool[i] = $urandom;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Every read command on the empty table, plus the unused codes.
		queue_cmd(CMD_FIRST, 32'h0, 32'h0);
		queue_cmd(CMD_LAST, 32'h0, 32'h0);
		queue_cmd(CMD_NEXT, 32'h0, 32'h0);
		queue_cmd(CMD_REWIND, 32'h0, 32'h0);
		queue_cmd(CMD_LOOKUP, 32'h0, 32'h0);
		queue_cmd(CMD_SPARE6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(CMD_SPARE7, 32'h0, 32'h0);
		drain();

		// A capacity of zero refuses every append.
		program_capacity(5'd0);
		queue_cmd(CMD_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();

		// Fill a two-entry table at the extremes of key and value, then walk it.
		program_capacity(5'd2);
		queue_cmd(CMD_APPEND, 32'h0, 32'h0);
		queue_cmd(CMD_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(CMD_APPEND, 32'h1234_5678, 32'h9ABC_DEF0);
		queue_cmd(CMD_FIRST, 32'h0, 32'h0);
		queue_cmd(CMD_LAST, 32'h0, 32'h0);
		queue_cmd(CMD_NEXT, 32'h0, 32'h0);
		queue_cmd(CMD_NEXT, 32'h0, 32'h0);
		queue_cmd(CMD_NEXT, 32'h0, 32'h0);
		queue_cmd(CMD_REWIND, 32'h0, 32'h0);
		queue_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		queue_cmd(CMD_NEXT, 32'h0, 32'h0);
		queue_cmd(CMD_LOOKUP, 32'h0, 32'h0);
		queue_cmd(CMD_NEXT, 32'h0, 32'h0);
		queue_cmd(CMD_LOOKUP, 32'hA5A5_A5A5, 32'h0);
		drain();

		// Random phases, each under its own capacity; later ones lower it below the count.
		foreach (phase_caps[p]) begin
			program_capacity(phase_caps[p]);
			add_random_items(125);
			drain();
		end

		if (mismatches == 0)
			$display("[keyed_append_table] OK");
		else
			$display("[keyed_append_table] ERROR");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/kat_pkg.sv
rtl/core/kat_if.sv
rtl/core/kat_cell.sv
rtl/core/keyed_append_table.sv
tb/tb.sv
